### design/dit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dit_pkg: shared types and codes for the disjoint interval tracker
// Transfer payloads, operation and result-kind codes, controller states.
// ----------------------------------------------------------------------------
package dit_pkg;

    // Width of the value and bound fields on the ports
    localparam int FIELD_BITS = 31;

    // Operation codes
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    // Result kinds
    localparam logic [2:0] KIND_ADDED    = 3'd0;
    localparam logic [2:0] KIND_PRESENT  = 3'd1;
    localparam logic [2:0] KIND_FULL     = 3'd2;
    localparam logic [2:0] KIND_INTERVAL = 3'd3;
    localparam logic [2:0] KIND_EMPTY    = 3'd4;

    // Input transfer
    typedef struct packed {
        logic                  opcode;
        logic [FIELD_BITS-1:0] value;
    } t_in_item;

    // Output transfer
    typedef struct packed {
        logic [2:0]            kind;
        logic [FIELD_BITS-1:0] range_start;
        logic [FIELD_BITS-1:0] range_end;
        logic                  last;
    } t_out_item;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_SHIFT,
        S_PLACE,
        S_RESULT,
        S_REPORT
    } t_state;

endpackage

### design/dit_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dit_mem: interval table storage
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dit_mem #(
    parameter  int DEPTH = 32,
    parameter  int WIDTH = 62,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/dit_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dit_ctrl: table sequencer
// Scans the table for the insert point, then extends, merges or inserts an
// interval by read-modify-write through the table RAM, unless the value is
// present or the table is full; streams the table on a report.
// ----------------------------------------------------------------------------
module dit_ctrl #(
    parameter  int MAX_INTERVALS = 32,
    parameter  int VALUE_BITS    = 31,
    localparam int AW            = $clog2(MAX_INTERVALS),
    localparam int EW            = 2 * VALUE_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  dit_pkg::t_in_item  i_in,
    output logic               o_in_stall,
    input  logic               i_out_free,
    output logic               o_emit_valid,
    output dit_pkg::t_out_item o_emit,
    output logic               o_mem_we,
    output logic [AW-1:0]      o_mem_waddr,
    output logic [EW-1:0]      o_mem_wdata,
    output logic [AW-1:0]      o_mem_raddr,
    input  logic [EW-1:0]      i_mem_rdata
);

    localparam int VB = VALUE_BITS;
    localparam int CW = $clog2(MAX_INTERVALS + 1);

    // Control state
    dit_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_pend, n_pend;
    // Work registers
    logic [VB-1:0]   r_v, n_v;
    logic [CW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_src, n_src;
    logic [CW-1:0]   r_p, n_p;
    logic [CW-1:0]   r_rem, n_rem;
    logic            r_up, n_up;
    logic [2:0]      r_kind, n_kind;
    logic [EW-1:0]   r_prev, n_prev;
    logic [EW-1:0]   r_next, n_next;
    logic            r_have_prev, n_have_prev;
    logic            r_have_next, n_have_next;

    // Shared decode
    logic          in_xfer;
    logic [VB-1:0] rd_start, rd_end;
    logic [VB-1:0] prev_start, prev_end, next_start, next_end;
    logic [VB:0]   prev_end_inc, v_inc;
    logic          srch_found;
    logic          covered, left, right, full;
    logic          rep_issue, rep_last;
    logic [CW-1:0] p_dec, src_inc, src_dec, count_dec;

    assign in_xfer      = i_in_valid && (r_state == dit_pkg::S_IDLE);
    assign rd_start     = i_mem_rdata[EW-1:VB];
    assign rd_end       = i_mem_rdata[VB-1:0];
    assign prev_start   = r_prev[EW-1:VB];
    assign prev_end     = r_prev[VB-1:0];
    assign next_start   = r_next[EW-1:VB];
    assign next_end     = r_next[VB-1:0];
    assign prev_end_inc = {1'b0, prev_end} + (VB+1)'(1);
    assign v_inc        = {1'b0, r_v} + (VB+1)'(1);

    // First entry whose start lies above the value marks the insert point
    assign srch_found = r_pend && (rd_start > r_v);

    assign covered = r_have_prev && (prev_end >= r_v);
    assign left    = r_have_prev && (prev_end_inc == {1'b0, r_v});
    assign right   = r_have_next && ({1'b0, next_start} == v_inc);
    assign full    = (r_count == CW'(MAX_INTERVALS));

    assign count_dec = r_count - CW'(1);
    assign p_dec     = r_p - CW'(1);
    assign src_inc   = r_src + CW'(1);
    assign src_dec   = r_src - CW'(1);

    // Report reads one entry at a time, only when the output slot frees up
    assign rep_issue = (r_state == dit_pkg::S_REPORT) && !r_pend &&
                       (r_idx < r_count) && i_out_free;
    assign rep_last  = (r_src == count_dec);

    // Next state and work registers
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pend      = r_pend;
        n_v         = r_v;
        n_idx       = r_idx;
        n_src       = r_src;
        n_p         = r_p;
        n_rem       = r_rem;
        n_up        = r_up;
        n_kind      = r_kind;
        n_prev      = r_prev;
        n_next      = r_next;
        n_have_prev = r_have_prev;
        n_have_next = r_have_next;
        case (r_state)
            dit_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_v         = VB'(i_in.value);
                    n_idx       = '0;
                    n_pend      = 1'b0;
                    n_have_prev = 1'b0;
                    n_have_next = 1'b0;
                    if (i_in.opcode == dit_pkg::OP_ADD) begin
                        n_state = dit_pkg::S_SEARCH;
                    end else begin
                        n_state = dit_pkg::S_REPORT;
                    end
                end
            end
            dit_pkg::S_SEARCH: begin
                if (srch_found) begin
                    n_next      = i_mem_rdata;
                    n_have_next = 1'b1;
                    n_p         = r_src;
                    n_pend      = 1'b0;
                    n_state     = dit_pkg::S_DECIDE;
                end else begin
                    if (r_pend) begin
                        n_prev      = i_mem_rdata;
                        n_have_prev = 1'b1;
                    end
                    if (r_idx == r_count) begin
                        n_p     = r_count;
                        n_pend  = 1'b0;
                        n_state = dit_pkg::S_DECIDE;
                    end else begin
                        n_src  = r_idx;
                        n_idx  = r_idx + CW'(1);
                        n_pend = 1'b1;
                    end
                end
            end
            dit_pkg::S_DECIDE: begin
                n_kind = dit_pkg::KIND_ADDED;
                if (covered) begin
                    n_kind  = dit_pkg::KIND_PRESENT;
                    n_state = dit_pkg::S_RESULT;
                end else if (left && right) begin
                    // Bridge: close the gap, then pull the tail down by one
                    n_count = count_dec;
                    n_idx   = r_p + CW'(1);
                    n_rem   = r_count - r_p - CW'(1);
                    n_up    = 1'b0;
                    n_state = dit_pkg::S_SHIFT;
                end else if (left || right) begin
                    n_state = dit_pkg::S_RESULT;
                end else if (full) begin
                    n_kind  = dit_pkg::KIND_FULL;
                    n_state = dit_pkg::S_RESULT;
                end else begin
                    // New interval: push the tail up by one, top entry first
                    n_count = r_count + CW'(1);
                    n_idx   = count_dec;
                    n_rem   = r_count - r_p;
                    n_up    = 1'b1;
                    n_state = dit_pkg::S_SHIFT;
                end
            end
            dit_pkg::S_SHIFT: begin
                if (r_rem != '0) begin
                    n_src  = r_idx;
                    n_pend = 1'b1;
                    n_idx  = r_up ? (r_idx - CW'(1)) : (r_idx + CW'(1));
                    n_rem  = r_rem - CW'(1);
                end else begin
                    n_pend  = 1'b0;
                    n_state = r_up ? dit_pkg::S_PLACE : dit_pkg::S_RESULT;
                end
            end
            dit_pkg::S_PLACE: begin
                n_state = dit_pkg::S_RESULT;
            end
            dit_pkg::S_RESULT: begin
                if (i_out_free) begin
                    n_state = dit_pkg::S_IDLE;
                end
            end
            dit_pkg::S_REPORT: begin
                if (r_count == '0) begin
                    if (i_out_free) begin
                        n_state = dit_pkg::S_IDLE;
                    end
                end else begin
                    n_pend = rep_issue;
                    if (rep_issue) begin
                        n_src = r_idx;
                        n_idx = r_idx + CW'(1);
                    end
                    if (r_pend && rep_last) begin
                        n_state = dit_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = dit_pkg::S_IDLE;
                n_pend  = 1'b0;
            end
        endcase
    end

    // Outputs: RAM ports, result and input stall
    always_comb begin
        o_in_stall   = (r_state != dit_pkg::S_IDLE);
        o_mem_raddr  = r_idx[AW-1:0];
        o_mem_we     = 1'b0;
        o_mem_waddr  = r_p[AW-1:0];
        o_mem_wdata  = i_mem_rdata;
        o_emit_valid = 1'b0;
        o_emit       = '0;
        case (r_state)
            dit_pkg::S_DECIDE: begin
                o_mem_we = !covered && (left || right);
                if (left && right) begin
                    o_mem_waddr = p_dec[AW-1:0];
                    o_mem_wdata = {prev_start, next_end};
                end else if (left) begin
                    o_mem_waddr = p_dec[AW-1:0];
                    o_mem_wdata = {prev_start, r_v};
                end else begin
                    o_mem_waddr = r_p[AW-1:0];
                    o_mem_wdata = {r_v, next_end};
                end
            end
            dit_pkg::S_SHIFT: begin
                o_mem_we    = r_pend;
                o_mem_waddr = r_up ? src_inc[AW-1:0] : src_dec[AW-1:0];
                o_mem_wdata = i_mem_rdata;
            end
            dit_pkg::S_PLACE: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_p[AW-1:0];
                o_mem_wdata = {r_v, r_v};
            end
            dit_pkg::S_RESULT: begin
                o_emit_valid = i_out_free;
                o_emit.kind  = r_kind;
                o_emit.last  = 1'b1;
            end
            dit_pkg::S_REPORT: begin
                if (r_count == '0) begin
                    o_emit_valid = i_out_free;
                    o_emit.kind  = dit_pkg::KIND_EMPTY;
                    o_emit.last  = 1'b1;
                end else begin
                    o_emit_valid       = r_pend;
                    o_emit.kind        = dit_pkg::KIND_INTERVAL;
                    o_emit.range_start = dit_pkg::FIELD_BITS'(rd_start);
                    o_emit.range_end   = dit_pkg::FIELD_BITS'(rd_end);
                    o_emit.last        = rep_last;
                end
            end
            default: begin
                o_mem_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dit_pkg::S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    // Work registers
    always_ff @(posedge i_clk) begin
        r_v         <= n_v;
        r_idx       <= n_idx;
        r_src       <= n_src;
        r_p         <= n_p;
        r_rem       <= n_rem;
        r_up        <= n_up;
        r_kind      <= n_kind;
        r_prev      <= n_prev;
        r_next      <= n_next;
        r_have_prev <= n_have_prev;
        r_have_next <= n_have_next;
    end

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_INTERVALS))
        else $error("interval count above table depth");

    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |-> (r_state == dit_pkg::S_DECIDE || r_state == dit_pkg::S_SHIFT ||
                      r_state == dit_pkg::S_PLACE))
        else $error("table write outside an update phase");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit_valid |-> i_out_free)
        else $error("result produced while output slot busy");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dit_pkg::S_IDLE) |-> !r_pend)
        else $error("read left in flight at idle");

    a_full_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dit_pkg::S_DECIDE && !covered && !left && !right && full)
        |=> (r_count == $past(r_count)))
        else $error("dropped value changed the table");

endmodule

### design/disjoint_interval_tracker.sv
`timescale 1ns / 1ps
// One item at a time: the input stalls until the current item is done. An add scans the
// table through the registered RAM read for the insert point, then decides and emits its
// result; a new interval also shifts the tail up and places the entry, a bridge shifts the
// tail down. A report reads and emits one interval at a time; output stalls add to both.
// Reset: synchronous active-low; clears the interval count and control state only, the
// table RAM is not cleared and entries at or above count are never read.
// ----------------------------------------------------------------------------
// disjoint_interval_tracker: sorted table of merged disjoint intervals
// Adds single values to the set with extend/merge/insert and lists the set.
// ----------------------------------------------------------------------------
module disjoint_interval_tracker #(
    parameter int MAX_INTERVALS = 32,
    parameter int VALUE_BITS    = 31
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dit_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dit_pkg::t_out_item o_out_item
);

    localparam int AW = $clog2(MAX_INTERVALS);
    localparam int EW = 2 * VALUE_BITS;

    logic               out_free;
    logic               emit_valid;
    dit_pkg::t_out_item emit;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [EW-1:0]      mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [EW-1:0]      mem_rdata;

    logic               r_out_valid;
    dit_pkg::t_out_item r_out_item;

    // Output slot is free when empty or being taken this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    dit_ctrl #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .VALUE_BITS    (VALUE_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in         (i_in_item),
        .o_in_stall   (o_in_stall),
        .i_out_free   (out_free),
        .o_emit_valid (emit_valid),
        .o_emit       (emit),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata)
    );

    dit_mem #(
        .DEPTH (MAX_INTERVALS),
        .WIDTH (EW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Output register: holds a result until its transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_valid) begin
            r_out_item <= emit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the disjoint interval tracker
// Directed adds and reports around zero, the top value, extension, bridging
// and an empty set, then random adds clustered in a few hot regions so that
// merges, duplicates and full-table drops all occur. Every result transfer
// is compared field by field with an in-bench model of the interval table.
// The input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TABLE_DEPTH   = 32;
    localparam int RANDOM_ITEMS  = 460;
    localparam int DRAIN_CYCLES  = 150;
    localparam int MAX_MISMATCH_LOG = 10;

    // Clock, reset and block ports
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    dit_pkg::t_in_item  i_in_item = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    dit_pkg::t_out_item o_out_item;

    disjoint_interval_tracker DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Interval table model and pending traffic
    logic [dit_pkg::FIELD_BITS-1:0] span_lo [TABLE_DEPTH];
    logic [dit_pkg::FIELD_BITS-1:0] span_hi [TABLE_DEPTH];
    int                 span_count = 0;
    dit_pkg::t_in_item  pending_items [$];
    dit_pkg::t_out_item expected_results [$];

    int  mismatch_count = 0;
    int  results_seen = 0;
    int  adds_sent = 0;
    int  reports_sent = 0;
    int  kind_seen [5] = '{0, 0, 0, 0, 0};
    int  sent_count = 0;
    int  send_gap = 0;
    int  stall_hold = 0;
    logic in_taken = 1'b0;
    logic [dit_pkg::FIELD_BITS-1:0] hot_base [6];

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void queue_item(logic op, logic [dit_pkg::FIELD_BITS-1:0] val);
        dit_pkg::t_in_item item;
        item.opcode = op;
        item.value  = val;
        pending_items = {pending_items, item};
        if (op == dit_pkg::OP_ADD) adds_sent++;
        else reports_sent++;
    endfunction

    function automatic void push_expected(logic [2:0] kind,
                                          logic [dit_pkg::FIELD_BITS-1:0] lo,
                                          logic [dit_pkg::FIELD_BITS-1:0] hi, logic fin);
        dit_pkg::t_out_item res;
        res.kind        = kind;
        res.range_start = lo;
        res.range_end   = hi;
        res.last        = fin;
        expected_results = {expected_results, res};
    endfunction

    // Apply one accepted transfer to the table model and queue its results
    function automatic void track_interval_item(dit_pkg::t_in_item item);
        int p;
        int i;
        logic joins_low;
        logic joins_high;
        logic [dit_pkg::FIELD_BITS:0] v;
        logic [2:0] kind;
        if (item.opcode == dit_pkg::OP_REPORT) begin
            if (span_count == 0) begin
                push_expected(dit_pkg::KIND_EMPTY, '0, '0, 1'b1);
            end else begin
                for (i = 0; i < span_count; i++)
                    push_expected(dit_pkg::KIND_INTERVAL, span_lo[i], span_hi[i],
                                  (i + 1 == span_count));
            end
            return;
        end
        v = {1'b0, item.value};
        p = 0;
        while (p < span_count && span_lo[p] <= item.value) p++;
        kind = dit_pkg::KIND_ADDED;
        if (p > 0 && span_hi[p-1] >= item.value) begin
            kind = dit_pkg::KIND_PRESENT;
        end else begin
            // adjacency is tested one bit wider, so no wrap at either end
            joins_low  = (p > 0) && (({1'b0, span_hi[p-1]} + 1) == v);
            joins_high = (p < span_count) && ({1'b0, span_lo[p]} == v + 1);
            if (joins_low && joins_high) begin
                span_hi[p-1] = span_hi[p];
                for (i = p; i + 1 < span_count; i++) begin
                    span_lo[i] = span_lo[i+1];
                    span_hi[i] = span_hi[i+1];
                end
                span_count--;
            end else if (joins_low) begin
                span_hi[p-1] = item.value;
            end else if (joins_high) begin
                span_lo[p] = item.value;
            end else if (span_count >= TABLE_DEPTH) begin
                kind = dit_pkg::KIND_FULL;
            end else begin
                for (i = span_count; i > p; i--) begin
                    span_lo[i] = span_lo[i-1];
                    span_hi[i] = span_hi[i-1];
                end
                span_lo[p] = item.value;
                span_hi[p] = item.value;
                span_count++;
            end
        end
        push_expected(kind, '0, '0, 1'b1);
    endfunction

    function automatic void note_mismatch(string what, dit_pkg::t_out_item want,
                                          dit_pkg::t_out_item got);
        mismatch_count++;
        if (mismatch_count <= MAX_MISMATCH_LOG)
            $display({"MISMATCH %s: expected kind=%0d start=%0d end=%0d last=%0d,",
                      " got kind=%0d start=%0d end=%0d last=%0d"},
                     what, want.kind, want.range_start, want.range_end, want.last,
                     got.kind, got.range_start, got.range_end, got.last);
    endfunction

    function automatic void check_result(dit_pkg::t_out_item got);
        dit_pkg::t_out_item want;
        if (expected_results.size() == 0) begin
            note_mismatch("unexpected result", '0, got);
            return;
        end
        want = expected_results.pop_front();
        if (got.kind !== want.kind || got.range_start !== want.range_start ||
            got.range_end !== want.range_end || got.last !== want.last)
            note_mismatch("field", want, got);
        if (got.kind <= dit_pkg::KIND_EMPTY) kind_seen[got.kind]++;
    endfunction

    // Monitor: check outputs first, then model the accepted input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                check_result(o_out_item);
            end
            if (i_in_valid && !o_in_stall)
                track_interval_item(i_in_item);
            in_taken <= i_in_valid && !o_in_stall;
        end
    end

    // Input driver: hold a stalled transfer, else gap or send the next one
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // payload stays put until accepted
        end else if (send_gap > 0) begin
            i_in_valid <= 1'b0;
            send_gap   <= send_gap - 1;
        end else if (pending_items.size() != 0) begin
            i_in_item  <= pending_items.pop_front();
            i_in_valid <= 1'b1;
            send_gap   <= (((sent_count / 48) % 4) == 2) ? 0 : pick_gap();
            sent_count <= sent_count + 1;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Output stall: random bursts, with stretches of none
    always @(negedge i_clk) begin
        if (stall_hold > 0) begin
            i_out_stall <= 1'b1;
            stall_hold  <= stall_hold - 1;
        end else begin
            i_out_stall <= 1'b0;
            if (((results_seen / 64) % 4) != 1 && $urandom_range(0, 3) == 0)
                stall_hold <= pick_gap();
        end
    end

    // Stimulus and end of run
    initial begin
        int n;
        int r;
        int drain;
        logic [dit_pkg::FIELD_BITS-1:0] val;

        // directed: empty set, zero, top value, extension both ways, bridging
        queue_item(dit_pkg::OP_REPORT, '0);
        queue_item(dit_pkg::OP_ADD, 31'd0);
        queue_item(dit_pkg::OP_ADD, 31'd0);
        queue_item(dit_pkg::OP_ADD, 31'd1);
        queue_item(dit_pkg::OP_ADD, 31'h7FFFFFFF);
        queue_item(dit_pkg::OP_ADD, 31'h7FFFFFFE);
        queue_item(dit_pkg::OP_ADD, 31'h7FFFFFFF);
        queue_item(dit_pkg::OP_ADD, 31'd5);
        queue_item(dit_pkg::OP_ADD, 31'd3);
        queue_item(dit_pkg::OP_ADD, 31'd4);
        queue_item(dit_pkg::OP_ADD, 31'd2);
        queue_item(dit_pkg::OP_REPORT, 31'h7FFFFFFF);
        queue_item(dit_pkg::OP_ADD, 31'h55555555);
        queue_item(dit_pkg::OP_ADD, 31'h2AAAAAAA);
        queue_item(dit_pkg::OP_ADD, 31'd10);
        queue_item(dit_pkg::OP_ADD, 31'd12);
        queue_item(dit_pkg::OP_ADD, 31'd11);
        queue_item(dit_pkg::OP_ADD, 31'd9);
        queue_item(dit_pkg::OP_REPORT, '0);

        // random: reports, scattered adds and adds clustered near a few bases so intervals touch and merge
        hot_base[0] = 31'd0;
        hot_base[1] = 31'h7FFFFF80;
        for (n = 2; n < 6; n++)
            hot_base[n] = dit_pkg::FIELD_BITS'($urandom()) & 31'h7FFFFF00;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                queue_item(dit_pkg::OP_REPORT, dit_pkg::FIELD_BITS'($urandom()));
            end else if (r < 22) begin
                queue_item(dit_pkg::OP_ADD, dit_pkg::FIELD_BITS'($urandom()));
            end else begin
                val = hot_base[$urandom_range(0, 5)] +
                      dit_pkg::FIELD_BITS'($urandom_range(0, 127));
                queue_item(dit_pkg::OP_ADD, val);
            end
        end
        queue_item(dit_pkg::OP_REPORT, '0);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_items.size() != 0 || i_in_valid) @(posedge i_clk);
        drain = 0;
        while (expected_results.size() != 0 && drain < 200000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $display("%0d expected results never arrived", expected_results.size());
            mismatch_count += expected_results.size();
        end

        $display("Run covered %0d adds and %0d reports; %0d results checked, %0d mismatches.",
                 adds_sent, reports_sent, results_seen, mismatch_count);
        $display("Kinds seen: added %0d, present %0d, dropped %0d, interval %0d, empty %0d.",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #30ms;
        $display("Timeout with %0d items pending and %0d results outstanding",
                 pending_items.size(), expected_results.size());
        $display("status: fail");
        $finish;
    end

endmodule

### disjoint_interval_tracker.f
design/dit_pkg.sv
design/dit_mem.sv
design/dit_ctrl.sv
design/disjoint_interval_tracker.sv
bench/testbench.sv
